// File: hw/rtl/bors_pkg.sv
`timescale 1ns / 1ps
package bors_pkg;

  localparam int unsigned FIELD_W     = 16;
  localparam int unsigned SCORE_W     = 16;
  localparam int unsigned MINOV_W     = 17;
  localparam int unsigned SCALE_W     = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned VERDICT_W   = 3;
  localparam int unsigned IN_TDATA_W  = 88;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned FRAC_SHIFT  = 16;

  typedef enum logic [1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_ADD   = 2'd1,
    FUNC_TEST  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    VERDICT_DONE     = 3'd0,
    VERDICT_KEPT     = 3'd1,
    VERDICT_ADJUSTED = 3'd2,
    VERDICT_DROPPED  = 3'd3,
    VERDICT_FULL     = 3'd4
  } verdict_e;

  typedef enum logic [1:0] {
    CFG_MIN_OVERLAP  = 2'd0,
    CFG_SUPPRESS_ALL = 2'd1,
    CFG_BORDER_SCALE = 2'd2
  } cfg_idx_e;

  localparam logic [KIND_W-1:0] KIND_SUPPRESS = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BORDER   = 2'd2;

  typedef struct packed {
    logic [MINOV_W-1:0] min_overlap;
    logic               suppress_all;
    logic [SCALE_W-1:0] border_scale;
  } cfg_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load;
    logic area_en;
    logic thresh_en;
    logic walk_rd;
    logic scale_en;
    logic finish;
  } cmd_t;

  // Status from the datapath back to the sequencer.
  typedef struct packed {
    logic in_is_test;
    logic count_zero;
    logic busy;
    logic out_free;
  } status_t;

endpackage

// File: hw/rtl/bors_ctrl.sv
`timescale 1ns / 1ps
module bors_ctrl import bors_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  status_t                               status_i,
  input  logic [$clog2(MAX_REGIONS+1)-1:0]      count_i,
  output cmd_t                                  cmd_o,
  output logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1)-1:0] rd_addr_o
);

  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_AREA   = 7'b0000010,
    S_THRESH = 7'b0000100,
    S_WALK   = 7'b0001000,
    S_DRAIN  = 7'b0010000,
    S_SCALE  = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] idx_next;

  assign idx_next   = idx_q + CNT_W'(1);
  assign in_ready_o = (state_q == S_IDLE);
  assign rd_addr_o  = idx_q[AW-1:0];

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = status_i.in_is_test ? S_AREA : S_FINISH;
        end
      end
      S_AREA: begin
        cmd_o.area_en = 1'b1;
        state_d       = S_THRESH;
      end
      S_THRESH: begin
        cmd_o.thresh_en = 1'b1;
        idx_d           = '0;
        state_d         = status_i.count_zero ? S_DRAIN : S_WALK;
      end
      S_WALK: begin
        cmd_o.walk_rd = 1'b1;
        idx_d         = idx_next;
        if (idx_next == count_i) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!status_i.busy) begin
          state_d = S_SCALE;
        end
      end
      S_SCALE: begin
        cmd_o.scale_en = 1'b1;
        state_d        = S_FINISH;
      end
      S_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// File: hw/rtl/bors_dp.sv
`timescale 1ns / 1ps
module bors_dp import bors_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic [IN_TDATA_W-1:0]                 in_tdata_i,
  input  logic [1:0]                            in_tuser_i,
  input  cfg_t                                  cfg_i,
  input  cmd_t                                  cmd_i,
  input  logic [((MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1)-1:0] rd_addr_i,
  output status_t                               status_o,
  output logic [$clog2(MAX_REGIONS+1)-1:0]      count_o,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [OUT_TDATA_W-1:0]                out_tdata_o,
  output logic [VERDICT_W-1:0]                  out_tuser_o
);

  localparam int unsigned CW      = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
  localparam int unsigned CNT_W   = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW      = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int unsigned ENTRY_W = 4 * CW + KIND_W;
  localparam int unsigned AREA_W  = 2 * CW;
  localparam int unsigned RHS_W   = AREA_W + MINOV_W;
  localparam int unsigned PROD_W  = SCORE_W + SCALE_W;

  // Input field positions in tdata.
  localparam int unsigned X0_LSB    = 0;
  localparam int unsigned Y0_LSB    = FIELD_W;
  localparam int unsigned X1_LSB    = 2 * FIELD_W;
  localparam int unsigned Y1_LSB    = 3 * FIELD_W;
  localparam int unsigned KIND_LSB  = 4 * FIELD_W;
  localparam int unsigned SCORE_LSB = KIND_LSB + KIND_W;

  logic [ENTRY_W-1:0] mem_q [MAX_REGIONS];

  func_e              func_in;
  logic [CW-1:0]      in_x0, in_y0, in_x1, in_y1;
  logic [KIND_W-1:0]  in_kind;

  func_e              func_q;
  logic [CW-1:0]      dx0_q, dy0_q, dx1_q, dy1_q;
  logic [SCORE_W-1:0] score_q;
  logic [CNT_W-1:0]   count_q;
  logic               full_q;
  logic               table_full;

  logic [AREA_W-1:0]  area_q;
  logic [RHS_W-1:0]   rhs_q;

  logic [ENTRY_W-1:0] rd_q;
  logic               v0_q, v1_q, v2_q;

  logic [CW-1:0]      rx0, ry0, rx1, ry1;
  logic [KIND_W-1:0]  rkind;
  logic [CW-1:0]      ix0, iy0, ix1, iy1;
  logic               nonempty;

  logic [CW-1:0]      dw1_q, dh1_q;
  logic               ne1_q, ne2_q;
  logic [KIND_W-1:0]  kind1_q, kind2_q;
  logic [AREA_W-1:0]  ov_q;
  logic [RHS_W-1:0]   lhs;
  logic               qual;

  logic               drop_q, adj_q;
  logic [PROD_W-1:0]  prod_q;

  logic                   out_valid_q;
  logic [VERDICT_W-1:0]   verdict_q;
  logic [SCORE_W-1:0]     oscore_q;
  verdict_e               verdict_d;
  logic [SCORE_W-1:0]     oscore_d;

  assign func_in = func_e'(in_tuser_i);
  assign in_x0   = in_tdata_i[X0_LSB +: CW];
  assign in_y0   = in_tdata_i[Y0_LSB +: CW];
  assign in_x1   = in_tdata_i[X1_LSB +: CW];
  assign in_y1   = in_tdata_i[Y1_LSB +: CW];
  assign in_kind = in_tdata_i[KIND_LSB +: KIND_W];

  assign table_full = (count_q == CNT_W'(MAX_REGIONS));

  // Item registers and the region count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      if (func_in == FUNC_CLEAR) begin
        count_q <= '0;
      end else if (func_in == FUNC_ADD && !table_full) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      func_q  <= func_in;
      dx0_q   <= in_x0;
      dy0_q   <= in_y0;
      dx1_q   <= in_x1;
      dy1_q   <= in_y1;
      score_q <= in_tdata_i[SCORE_LSB +: SCORE_W];
      full_q  <= table_full;
    end
  end

  // Region table: one write port at append, one registered read port for the walk.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && func_in == FUNC_ADD && !table_full) begin
      mem_q[count_q[AW-1:0]] <= {in_kind, in_y1, in_x1, in_y0, in_x0};
    end
    if (cmd_i.walk_rd) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  // Detection area, then the right-hand side of the share test.
  always_ff @(posedge clk_i) begin
    if (cmd_i.area_en) begin
      area_q <= AREA_W'(dx1_q - dx0_q) * AREA_W'(dy1_q - dy0_q);
    end
    if (cmd_i.thresh_en) begin
      rhs_q <= RHS_W'(area_q) * RHS_W'(cfg_i.min_overlap);
    end
  end

  // Intersection of the fetched region with the detection.
  assign {rkind, ry1, rx1, ry0, rx0} = rd_q;
  assign ix0      = (dx0_q > rx0) ? dx0_q : rx0;
  assign iy0      = (dy0_q > ry0) ? dy0_q : ry0;
  assign ix1      = (dx1_q < rx1) ? dx1_q : rx1;
  assign iy1      = (dy1_q < ry1) ? dy1_q : ry1;
  assign nonempty = (ix0 < ix1) && (iy0 < iy1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.walk_rd;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dw1_q   <= ix1 - ix0;
    dh1_q   <= iy1 - iy0;
    ne1_q   <= nonempty;
    kind1_q <= rkind;
    ov_q    <= AREA_W'(dw1_q) * AREA_W'(dh1_q);
    ne2_q   <= ne1_q;
    kind2_q <= kind1_q;
  end

  // overlap * 2^16 >= min_overlap * detection area
  assign lhs  = RHS_W'({ov_q, FRAC_SHIFT'(0)});
  assign qual = v2_q && ne2_q && (lhs >= rhs_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_q <= 1'b0;
      adj_q  <= 1'b0;
    end else if (cmd_i.load) begin
      drop_q <= 1'b0;
      adj_q  <= 1'b0;
    end else if (qual) begin
      if (kind2_q == KIND_SUPPRESS || cfg_i.suppress_all) begin
        drop_q <= 1'b1;
      end else if (kind2_q == KIND_BORDER) begin
        adj_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_en) begin
      prod_q <= PROD_W'(score_q) * PROD_W'(cfg_i.border_scale);
    end
  end

  always_comb begin
    verdict_d = VERDICT_DONE;
    oscore_d  = '0;
    case (func_q)
      FUNC_ADD: begin
        verdict_d = full_q ? VERDICT_FULL : VERDICT_DONE;
      end
      FUNC_TEST: begin
        if (drop_q) begin
          verdict_d = VERDICT_DROPPED;
        end else if (adj_q) begin
          verdict_d = VERDICT_ADJUSTED;
          // The product with the Q4.12 scale, shifted down by twelve, saturates to the score range.
          oscore_d  = (prod_q[PROD_W-1:SCORE_W+12] != '0) ? '1 : prod_q[SCORE_W+11:12];
        end else begin
          verdict_d = VERDICT_KEPT;
          oscore_d  = score_q;
        end
      end
      default: begin
        verdict_d = VERDICT_DONE;
      end
    endcase
  end

  // Output register: holds a finished result while the next item is worked on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      verdict_q <= verdict_d;
      oscore_q  <= oscore_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_tdata_o = oscore_q;
  assign out_tuser_o = verdict_q;
  assign count_o     = count_q;

  assign status_o.in_is_test = (func_in == FUNC_TEST);
  assign status_o.count_zero = (count_q == '0);
  assign status_o.busy       = v0_q | v1_q | v2_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

// File: hw/rtl/box_overlap_region_suppressor.sv
`timescale 1ns / 1ps
// A clear or add item goes from idle straight to the finish state; a detection test passes
// through the area, threshold, walk, drain, scale and finish states, skipping the walk on
// an empty table. One item at a time: the next is accepted once the sequencer is back in
// idle; the test time is set by the walk over the table, one entry per cycle, and a result
// still held at the output stalls the finish. Reset clears the region count, the sequencer
// and the output valid and loads the configuration defaults; the table is not cleared.
module box_overlap_region_suppressor import bors_pkg::*; #(
  parameter int unsigned MAX_REGIONS = 64,
  parameter int unsigned COORD_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // x_min[15:0], y_min[31:16], x_max[47:32], y_max[63:48], region_kind[65:64],
  // score[81:66], zero[87:82]
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // func[1:0]
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // out_score[15:0]
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // verdict[2:0]
  output logic [VERDICT_W-1:0]   m_axis_tuser,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int unsigned AW    = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;

  cfg_t             cfg_q;
  cmd_t             cmd;
  status_t          status;
  logic [CNT_W-1:0] count;
  logic [AW-1:0]    rd_addr;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_overlap  <= MINOV_W'(32768);
      cfg_q.suppress_all <= 1'b0;
      cfg_q.border_scale <= SCALE_W'(4096);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_OVERLAP:  cfg_q.min_overlap  <= cfg_data_i[MINOV_W-1:0];
        CFG_SUPPRESS_ALL: cfg_q.suppress_all <= cfg_data_i[0];
        CFG_BORDER_SCALE: cfg_q.border_scale <= cfg_data_i[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  bors_ctrl #(
    .MAX_REGIONS(MAX_REGIONS)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .status_i  (status),
    .count_i   (count),
    .cmd_o     (cmd),
    .rd_addr_o (rd_addr)
  );

  bors_dp #(
    .MAX_REGIONS(MAX_REGIONS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_tdata_i (s_axis_tdata),
    .in_tuser_i (s_axis_tuser),
    .cfg_i      (cfg_q),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .status_o   (status),
    .count_o    (count),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_tdata_o(m_axis_tdata),
    .out_tuser_o(m_axis_tuser)
  );

  // One item at a time: the input side closes straight after an item is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is still in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(MAX_REGIONS))
    else $error("region count beyond table depth");

  // Dropped detections and region operations carry a zero score.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == VERDICT_DROPPED || m_axis_tuser == VERDICT_DONE ||
                      m_axis_tuser == VERDICT_FULL) |-> m_axis_tdata == '0)
    else $error("nonzero score on a result that carries none");

  // The walk pipeline is empty whenever a new item can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> !status.busy)
    else $error("region walk still running while idle");

endmodule

// File: tb/box_overlap_region_suppressor_test.sv
`timescale 1ns / 1ps
module box_overlap_region_suppressor_test;
  import bors_pkg::*;

  localparam int unsigned MAX_REGIONS = 64;
  localparam int unsigned COORD_BITS  = 16;
  localparam int unsigned QUIET_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS = 125;

  typedef struct packed {
    logic [15:0] x0;
    logic [15:0] y0;
    logic [15:0] x1;
    logic [15:0] y1;
  } box_t;

  typedef struct packed {
    func_e       func;
    box_t        b;
    logic [1:0]  kind;
    logic [15:0] score;
  } item_t;

  typedef struct packed {
    verdict_e    verdict;
    logic [15:0] score;
  } outcome_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic [1:0]             s_axis_tuser = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [VERDICT_W-1:0]   m_axis_tuser;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;

  box_overlap_region_suppressor #(
    .MAX_REGIONS(MAX_REGIONS),
    .COORD_BITS (COORD_BITS)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Predicted state of the block.
  box_t        zone_box[MAX_REGIONS];
  logic [1:0]  zone_kind[MAX_REGIONS];
  int unsigned zone_count = 0;
  logic [16:0] min_share = 17'd32768;
  bit          drop_any = 1'b0;
  logic [15:0] soft_gain = 16'd4096;

  item_t       pending_q[$];
  outcome_t    outcome_q[$];
  item_t       next_item;
  item_t       seen_item;
  outcome_t    want;
  int unsigned pushed_count = 0;
  int unsigned counted_items = 0;
  int unsigned sent_count = 0;
  int unsigned accepted_count = 0;
  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned idle_pct = 18;
  bit          stuck = 1'b0;
  bit          run_done = 1'b0;

  function automatic bit covers_enough(box_t d, box_t r);
    logic [15:0] ix0, ix1, iy0, iy1;
    logic [63:0] ov, da;
    ix0 = (d.x0 > r.x0) ? d.x0 : r.x0;
    ix1 = (d.x1 < r.x1) ? d.x1 : r.x1;
    iy0 = (d.y0 > r.y0) ? d.y0 : r.y0;
    iy1 = (d.y1 < r.y1) ? d.y1 : r.y1;
    if (!(ix0 < ix1 && iy0 < iy1)) return 1'b0;
    ov = 64'(ix1 - ix0) * 64'(iy1 - iy0);
    // A nonempty intersection implies the detection itself is well formed.
    da = 64'(d.x1 - d.x0) * 64'(d.y1 - d.y0);
    return (ov << 16) >= da * 64'(min_share);
  endfunction

  function automatic outcome_t settle_item(item_t it);
    outcome_t    res;
    bit          drop, soften;
    logic [31:0] prod;
    int unsigned i;
    res.verdict = VERDICT_DONE;
    res.score = '0;
    case (it.func)
      FUNC_CLEAR: zone_count = 0;
      FUNC_ADD: begin
        if (zone_count >= MAX_REGIONS) begin
          res.verdict = VERDICT_FULL;
        end else begin
          zone_box[zone_count] = it.b;
          zone_kind[zone_count] = it.kind;
          zone_count++;
        end
      end
      FUNC_TEST: begin
        drop = 1'b0;
        soften = 1'b0;
        for (i = 0; i < zone_count; i++) begin
          if (covers_enough(it.b, zone_box[i])) begin
            if (zone_kind[i] == KIND_SUPPRESS || drop_any) drop = 1'b1;
            else if (zone_kind[i] == KIND_BORDER) soften = 1'b1;
          end
        end
        if (drop) begin
          res.verdict = VERDICT_DROPPED;
        end else if (soften) begin
          prod = (32'(it.score) * 32'(soft_gain)) >> 12;
          res.verdict = VERDICT_ADJUSTED;
          res.score = (prod > 32'hFFFF) ? 16'hFFFF : prod[15:0];
        end else begin
          res.verdict = VERDICT_KEPT;
          res.score = it.score;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic void flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $realtime, what);
  endfunction

  // Driver: presents queued items and toggles the result stall at the falling edge.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      m_axis_tready <= ($urandom_range(0, 99) >= idle_pct);
      if (sent_count == accepted_count) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          next_item = pending_q.pop_front();
          s_axis_tdata <= {6'b0, next_item.score, next_item.kind, next_item.b.y1,
                           next_item.b.x1, next_item.b.y0, next_item.b.x0};
          s_axis_tuser <= next_item.func;
          s_axis_tvalid <= 1'b1;
          sent_count++;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: tracks settings and items, checks results, watches for a hang.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_MIN_OVERLAP:  min_share = cfg_data_i;
          CFG_SUPPRESS_ALL: drop_any = cfg_data_i[0];
          CFG_BORDER_SCALE: soft_gain = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (outcome_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result: verdict %0d score %0d",
                                  m_axis_tuser, m_axis_tdata));
        end else begin
          want = outcome_q.pop_front();
          if (m_axis_tuser !== want.verdict)
            flag_mismatch($sformatf("verdict: got %0d, wanted %0d",
                                    m_axis_tuser, want.verdict));
          if (m_axis_tdata !== want.score)
            flag_mismatch($sformatf("score: got %0d, wanted %0d",
                                    m_axis_tdata, want.score));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        seen_item.func = func_e'(s_axis_tuser);
        seen_item.b.x0 = s_axis_tdata[15:0];
        seen_item.b.y0 = s_axis_tdata[31:16];
        seen_item.b.x1 = s_axis_tdata[47:32];
        seen_item.b.y1 = s_axis_tdata[63:48];
        seen_item.kind = s_axis_tdata[65:64];
        seen_item.score = s_axis_tdata[81:66];
        outcome_q.push_back(settle_item(seen_item));
        accepted_count++;
      end
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) stuck = 1'b1;
      end
    end
  end

  task automatic push_item(func_e func, box_t b, logic [1:0] kind, logic [15:0] score);
    item_t it;
    it.func = func;
    it.b = b;
    it.kind = kind;
    it.score = score;
    pending_q.push_back(it);
    pushed_count++;
    if (func != FUNC_NONE) counted_items++;
  endtask

  function automatic box_t make_box(int unsigned x0, int unsigned y0, int unsigned x1,
                                    int unsigned y1);
    box_t b;
    b.x0 = 16'(x0);
    b.y0 = 16'(y0);
    b.x1 = 16'(x1);
    b.y1 = 16'(y1);
    return b;
  endfunction

  // Box close to a cluster origin; now and then empty or inverted.
  function automatic box_t near_box(int unsigned cx, int unsigned cy);
    box_t        b;
    logic [15:0] t;
    b.x0 = 16'(cx + $urandom_range(0, 160));
    b.y0 = 16'(cy + $urandom_range(0, 160));
    b.x1 = 16'(b.x0 + $urandom_range(0, 120));
    b.y1 = 16'(b.y0 + $urandom_range(0, 120));
    if ($urandom_range(0, 19) == 0) begin
      t = b.x0;
      b.x0 = b.x1;
      b.x1 = t;
    end
    return b;
  endfunction

  function automatic box_t wild_box();
    return make_box($urandom_range(0, 65535), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535));
  endfunction

  function automatic logic [15:0] any_score();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(0, 65535));
  endfunction

  // An optional clear, a run of adds and a few detections near those regions, or one random item.
  task automatic add_sequence(bit fill);
    int unsigned cx, cy, n, m, i;
    box_t        made[$];
    box_t        d;
    if (!fill && $urandom_range(0, 99) < 20) begin
      push_item(func_e'($urandom_range(0, 3)), wild_box(), 2'($urandom_range(0, 3)),
                16'($urandom_range(0, 65535)));
      return;
    end
    cx = $urandom_range(0, 65535 - 400);
    cy = $urandom_range(0, 65535 - 400);
    if (fill || $urandom_range(0, 99) < 70) push_item(FUNC_CLEAR, wild_box(), 2'd0, 16'd0);
    n = fill ? $urandom_range(64, 68) : $urandom_range(0, 10);
    for (i = 0; i < n; i++) begin
      d = ($urandom_range(0, 19) == 0) ? wild_box() : near_box(cx, cy);
      made.push_back(d);
      push_item(FUNC_ADD, d, 2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)));
    end
    m = $urandom_range(1, 6);
    for (i = 0; i < m; i++) begin
      if (made.size() != 0 && $urandom_range(0, 99) < 30)
        d = made[$urandom_range(0, made.size() - 1)];
      else if ($urandom_range(0, 19) == 0)
        d = wild_box();
      else
        d = near_box(cx, cy);
      push_item(FUNC_TEST, d, 2'($urandom_range(0, 3)), any_score());
    end
  endtask

  task automatic drain();
    while (accepted_count != pushed_count || outcome_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_setting(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_phase(int unsigned idle);
    int unsigned start;
    idle_pct = idle;
    start = counted_items;
    add_sequence(1'b1);
    while (counted_items - start < PHASE_ITEMS) add_sequence(1'b0);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed items under the reset settings.
    push_item(FUNC_TEST, make_box(100, 100, 200, 200), 2'd0, 16'hFFFF);
    push_item(FUNC_NONE, wild_box(), 2'd3, 16'hFFFF);
    push_item(FUNC_ADD, make_box(10, 10, 110, 110), 2'd1, 16'd0);
    push_item(FUNC_ADD, make_box(1000, 1000, 1100, 1100), 2'd2, 16'd0);
    push_item(FUNC_ADD, make_box(2000, 2000, 2100, 2100), 2'd0, 16'd0);
    push_item(FUNC_ADD, make_box(3000, 3000, 3100, 3100), 2'd3, 16'd0);
    push_item(FUNC_TEST, make_box(10, 10, 110, 110), 2'd0, 16'hFFFF);
    push_item(FUNC_TEST, make_box(1000, 1000, 1100, 1100), 2'd0, 16'hFFFF);
    // Exactly half the detection is covered, then just under half.
    push_item(FUNC_TEST, make_box(1000, 1000, 1200, 1100), 2'd0, 16'h8001);
    push_item(FUNC_TEST, make_box(1000, 1000, 1201, 1100), 2'd0, 16'h8001);
    push_item(FUNC_TEST, make_box(2000, 2000, 2100, 2100), 2'd0, 16'h1357);
    push_item(FUNC_TEST, make_box(3000, 3000, 3100, 3100), 2'd0, 16'h2468);
    push_item(FUNC_TEST, make_box(110, 110, 10, 10), 2'd0, 16'h0101);
    push_item(FUNC_TEST, make_box(10, 10, 10, 110), 2'd0, 16'h0202);
    push_item(FUNC_TEST, make_box(110, 10, 210, 110), 2'd0, 16'h0303);
    push_item(FUNC_TEST, make_box(0, 0, 65535, 65535), 2'd0, 16'h0000);
    push_item(FUNC_ADD, make_box(0, 0, 65535, 65535), 2'd2, 16'd0);
    push_item(FUNC_TEST, make_box(5000, 5000, 5001, 5001), 2'd0, 16'h1234);
    push_item(FUNC_TEST, make_box(65534, 65534, 65535, 65535), 2'd3, 16'hFFFF);
    push_item(FUNC_CLEAR, make_box(65535, 65535, 65535, 65535), 2'd3, 16'hFFFF);
    push_item(FUNC_TEST, make_box(10, 10, 110, 110), 2'd0, 16'hABCD);
    push_item(FUNC_ADD, make_box(65535, 65535, 65535, 65535), 2'd3, 16'hFFFF);
    push_item(FUNC_CLEAR, make_box(0, 0, 0, 0), 2'd0, 16'd0);
    random_phase(18);

    // Any nonempty intersection counts; a stretch without stalls.
    write_setting(CFG_MIN_OVERLAP, 0);
    write_setting(CFG_SUPPRESS_ALL, 0);
    write_setting(CFG_BORDER_SCALE, 65535);
    random_phase(0);

    write_setting(CFG_MIN_OVERLAP, 65536);
    write_setting(CFG_SUPPRESS_ALL, 1);
    write_setting(CFG_BORDER_SCALE, 0);
    random_phase(18);

    // A threshold above one can never be met.
    write_setting(CFG_MIN_OVERLAP, 131071);
    write_setting(CFG_SUPPRESS_ALL, 0);
    write_setting(CFG_BORDER_SCALE, 6000);
    random_phase(18);

    write_setting(CFG_MIN_OVERLAP, $urandom_range(1, 65535));
    write_setting(CFG_BORDER_SCALE, $urandom_range(1, 65534));
    random_phase(18);

    repeat (MAX_REGIONS + 16) @(posedge clk_i);
    run_done = 1'b1;
  end

  initial begin
    wait (run_done || stuck);
    if (outcome_q.size() != 0) $display("%0d results never arrived", outcome_q.size());
    if (!stuck && mismatches == 0 && outcome_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
